// File: hw/rtl/tssg_pkg.sv
package tssg_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT_DIV,
        ST_SPLIT_DONE,
        ST_LSLOPE_DIV,
        ST_RSLOPE_DIV,
        ST_READY,
        ST_STEP,
        ST_OUT
    } tssg_state_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [11:0] WIDTH_RESET  = 12'd800;
    localparam logic [11:0] HEIGHT_RESET = 12'd600;

    typedef struct packed {
        logic load;        // latch and sort a start item
        logic split_go;    // start the split_x division
        logic split_take;  // store split_x
        logic half_up;     // set up the flat-top half (else flat-bottom)
        logic lslope_go;   // start left slope division
        logic rslope_go;   // start right slope division
        logic lslope_take;
        logic rslope_take;
        logic step;        // advance edges and row, build output
    } tssg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic flat;        // y1 == y3
        logic top_flat;    // y1 == y2
        logic go_up;       // after this down step, continue with the lower half
        logic end_tri;     // after this step the triangle is finished
    } tssg_status_t;

endpackage

// File: hw/rtl/tssg_if.sv
interface tssg_in_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [31:0]                  fill;
    modport source (output valid, operation, ax, ay, bx, by, cx, cy, fill, input ready);
    modport sink   (input valid, operation, ax, ay, bx, by, cx, cy, fill, output ready);
endinterface

interface tssg_out_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] span_y;
    logic [11:0]                  span_left;
    logic [11:0]                  span_right;
    logic [31:0]                  span_color;
    logic                         span_visible;
    logic                         span_last;
    modport source (output valid, span_y, span_left, span_right, span_color, span_visible,
                    span_last, input ready);
    modport sink   (input valid, span_y, span_left, span_right, span_color, span_visible,
                    span_last, output ready);
endinterface

interface tssg_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tssg_divider.sv
module tssg_divider #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    // Unsigned restoring division, one quotient bit per cycle.
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        if (go)
        begin
            q_next    = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // The final quotient bit is formed in the done cycle, even if a new division starts then.
    assign done = busy_reg && (cnt_reg == CNT_BITS'(1));
    assign quot = {q_reg[NUM_BITS-2:0], (trial >= {1'b0, den_reg})};
endmodule

// File: hw/rtl/tssg_datapath.sv
module tssg_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tssg_pkg::tssg_cmd_t          cmd,
    output tssg_pkg::tssg_status_t       status,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic [31:0]                  fill,
    input  logic [11:0]                  screen_width,
    input  logic [11:0]                  screen_height,
    output logic signed [COORD_BITS-1:0] span_y,
    output logic [11:0]                  span_left,
    output logic [11:0]                  span_right,
    output logic [31:0]                  span_color,
    output logic                         span_visible,
    output logic                         span_last
);
    import tssg_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int DB  = CB + 1;                 // coordinate difference
    localparam int PB  = 2 * DB + 1;             // split numerator magnitude
    localparam int SB  = DB + FRAC_BITS + 2;     // slope numerator magnitude
    localparam int NB  = (PB > SB) ? PB : SB;
    localparam int EB  = CB + FRAC_BITS + 3;     // edge accumulator
    localparam int COLB = CB + 3;

    logic signed [CB-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [CB-1:0] sx_reg;
    logic signed [CB+1:0] row_reg;
    logic signed [EB-1:0] le_reg, re_reg, ls_reg, rs_reg;
    logic [31:0]          col_reg;
    logic                 neg_reg;

    // Three-comparator stable sort network.
    logic signed [CB-1:0] px [3];
    logic signed [CB-1:0] py [3];
    logic signed [CB-1:0] tx, ty;

    always_comb
    begin
        tx = '0;
        ty = '0;
        px[0] = ax; py[0] = ay;
        px[1] = bx; py[1] = by;
        px[2] = cx; py[2] = cy;
        if (py[0] > py[1])
        begin
            tx = px[0]; ty = py[0]; px[0] = px[1]; py[0] = py[1]; px[1] = tx; py[1] = ty;
        end
        if (py[1] > py[2])
        begin
            tx = px[1]; ty = py[1]; px[1] = px[2]; py[1] = py[2]; px[2] = tx; py[2] = ty;
        end
        if (py[0] > py[1])
        begin
            tx = px[0]; ty = py[0]; px[0] = px[1]; py[0] = py[1]; px[1] = tx; py[1] = ty;
        end
    end

    // Divider operand selection.
    logic signed [DB-1:0] dy13, dy12, dy23, dyh;
    logic signed [PB:0]   split_num;
    logic signed [CB-1:0] apex_x, lo_x, hi_x;
    logic signed [DB-1:0] ldx, rdx;
    logic signed [SB:0]   snum;
    logic [NB-1:0]        dnum, dq;
    logic [DB-1:0]        dden;
    logic                 dgo, ddone;
    logic signed [NB:0]   sq;

    always_comb
    begin
        dy13 = DB'(y3_reg) - DB'(y1_reg);
        dy12 = DB'(y2_reg) - DB'(y1_reg);
        dy23 = DB'(y3_reg) - DB'(y2_reg);
        dyh  = cmd.half_up ? dy23 : dy12;
        apex_x = cmd.half_up ? x3_reg : x1_reg;
        lo_x = (sx_reg < x2_reg) ? sx_reg : x2_reg;
        hi_x = (sx_reg < x2_reg) ? x2_reg : sx_reg;
        ldx = DB'(lo_x) - DB'(apex_x);
        rdx = DB'(hi_x) - DB'(apex_x);
        split_num = (PB+1)'(x1_reg) * (PB+1)'(dy13)
                  + (PB+1)'(DB'(x3_reg) - DB'(x1_reg)) * (PB+1)'(dy12);
        snum = (SB+1)'(cmd.rslope_go ? rdx : ldx) <<< FRAC_BITS;
        dgo  = cmd.split_go | cmd.lslope_go | cmd.rslope_go;
        if (cmd.split_go)
        begin
            // truncating division
            dnum = split_num[PB] ? NB'(-split_num) : NB'(split_num);
            dden = dy13;
        end
        else
        begin
            // rounding: (2|n| + d) / 2d
            dnum = NB'({(snum[SB] ? -snum : snum), 1'b0}) + NB'(dyh);
            dden = {dyh[DB-2:0], 1'b0};
        end
    end

    tssg_divider #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .clk(clk), .rst_n(rst_n), .go(dgo), .numer(dnum), .denom(dden),
        .done(ddone), .quot(dq)
    );

    always_ff @(posedge clk)
    begin
        if (dgo)
            neg_reg <= cmd.split_go ? split_num[PB] : snum[SB];
    end

    assign sq = neg_reg ? -(NB+1)'(dq) : (NB+1)'(dq);

    // Step arithmetic.
    logic signed [EB-1:0]   le_n, re_n;
    logic signed [COLB-1:0] lcol, rcol, wmax;
    logic signed [CB+1:0]   row_n;
    logic                   vis;

    function automatic logic signed [COLB-1:0] edge_col(input logic signed [EB-1:0] e);
        logic [EB-1:0] a;
        logic [EB-1:0] r;
        a = e[EB-1] ? EB'(-e) : EB'(e);
        r = (a + (EB'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return e[EB-1] ? -COLB'(r) : COLB'(r);
    endfunction

    always_comb
    begin
        le_n = le_reg + ls_reg;
        re_n = re_reg + rs_reg;
        lcol = edge_col(le_n);
        rcol = edge_col(re_n);
        // A zero width gives a limit of -1, so every span is then empty.
        wmax = $signed(COLB'(screen_width)) - COLB'(1);
        if (lcol < 0)
            lcol = '0;
        if (rcol > wmax)
            rcol = wmax;
        vis = (row_reg >= 0) && (row_reg < (CB+2)'(screen_height)) && (lcol <= rcol);
        row_n = cmd.half_up ? row_reg - 1'b1 : row_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0; y1_reg <= '0; x2_reg <= '0;
            y2_reg <= '0; x3_reg <= '0; y3_reg <= '0;
            sx_reg <= '0; row_reg <= '0; col_reg <= '0;
            le_reg <= '0; re_reg <= '0; ls_reg <= '0; rs_reg <= '0;
            span_y <= '0; span_left <= '0; span_right <= '0;
            span_color <= '0; span_visible <= 1'b0; span_last <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                x1_reg <= px[0]; y1_reg <= py[0];
                x2_reg <= px[1]; y2_reg <= py[1];
                x3_reg <= px[2]; y3_reg <= py[2];
                col_reg <= fill;
            end
            if (cmd.split_take)
                sx_reg <= CB'(sq);
            if (cmd.lslope_take)
            begin
                ls_reg  <= EB'(sq);
                le_reg  <= EB'(apex_x) <<< FRAC_BITS;
                re_reg  <= EB'(apex_x) <<< FRAC_BITS;
                row_reg <= cmd.half_up ? (CB+2)'(y3_reg) - 1'b1 : (CB+2)'(y1_reg) + 1'b1;
            end
            if (cmd.rslope_take)
                rs_reg <= EB'(sq);
            if (cmd.step)
            begin
                le_reg  <= le_n;
                re_reg  <= re_n;
                row_reg <= row_n;
                span_y  <= CB'(row_reg);
                span_left  <= vis ? 12'(lcol) : 12'd0;
                span_right <= vis ? 12'(rcol) : 12'd0;
                span_visible <= vis;
                span_last  <= (row_reg == (CB+2)'(y2_reg)) && (cmd.half_up || y2_reg == y3_reg);
                span_color <= col_reg;
            end
        end
    end

    assign status.div_done = ddone;
    assign status.flat     = (py[0] == py[2]);
    assign status.top_flat = (y1_reg == y2_reg);
    assign status.go_up    = !cmd.half_up && (row_reg == (CB+2)'(y2_reg)) && (y3_reg > y2_reg);
    assign status.end_tri  = (row_reg == (CB+2)'(y2_reg)) && (cmd.half_up || y3_reg == y2_reg);
endmodule

// File: hw/rtl/tssg_control.sv
module tssg_control (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_op,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  tssg_pkg::tssg_status_t status,
    output tssg_pkg::tssg_cmd_t    cmd,
    output logic                   idle
);
    import tssg_pkg::*;

    tssg_state_t state_reg, state_next;
    logic        up_reg, up_next;
    logic        act_reg, act_next;
    // A down half that hands over to the up half needs fresh slopes.
    logic        handover_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            up_reg    <= 1'b0;
            act_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            up_reg    <= up_next;
            act_reg   <= act_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        up_next    = up_reg;
        act_next   = act_reg;
        cmd        = '0;
        cmd.half_up = up_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        idle       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                idle     = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_START)
                    begin
                        cmd.load   = 1'b1;
                        act_next   = 1'b0;
                        if (!status.flat)
                            state_next = ST_SPLIT_DIV;
                    end
                    else if (act_reg)
                        state_next = ST_STEP;
                end
            end
            ST_SPLIT_DIV:
            begin
                cmd.split_go = 1'b1;
                state_next   = ST_SPLIT_DONE;
            end
            ST_SPLIT_DONE:
            begin
                if (status.div_done)
                begin
                    cmd.split_take = 1'b1;
                    up_next        = status.top_flat;
                    state_next     = ST_LSLOPE_DIV;
                end
            end
            ST_LSLOPE_DIV:
            begin
                cmd.lslope_go = 1'b1;
                state_next    = ST_READY;
            end
            ST_READY:
            begin
                if (status.div_done)
                begin
                    cmd.lslope_take = 1'b1;
                    cmd.rslope_go   = 1'b1;
                    state_next      = ST_RSLOPE_DIV;
                end
            end
            ST_RSLOPE_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.rslope_take = 1'b1;
                    act_next        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                state_next = ST_OUT;
                if (status.go_up)
                begin
                    up_next = 1'b1;
                    act_next = 1'b0;
                end
                else if (status.end_tri)
                    act_next = 1'b0;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
                if (out_ready && up_reg && !act_reg && handover_reg)
                    state_next = ST_LSLOPE_DIV;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            handover_reg <= 1'b0;
        else if (state_reg == ST_STEP)
            handover_reg <= status.go_up;
        else if (state_reg == ST_OUT && out_ready)
            handover_reg <= 1'b0;
    end
endmodule

// File: hw/rtl/triangle_scanline_span_generator.sv
// Span generator for filled triangles, one span per step transfer while a triangle is active.
// A start transfer of a triangle that is not flat (y1 != y3) runs its set-up (split point, both
// slopes) in one shared bit-serial divider of D = max(2*COORD_BITS, COORD_BITS+FRAC_BITS)+3 bits.
// A step registers its span in the step state and offers it in the output state until taken; no
// new transfer is accepted before that. Crossing to the lower half repeats both slope divisions.
// Reset (asynchronous, rst_n low) clears all but the division registers; idle, width 800, height 600.
module triangle_scanline_span_generator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tssg_in_if.sink    in_ch,
    tssg_out_if.source out_ch,
    tssg_cfg_if.sink   cfg
);
    import tssg_pkg::*;

    tssg_cmd_t    cmd;
    tssg_status_t status;
    logic         idle;
    logic [11:0]  width_reg, height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SCREEN_WIDTH)
                width_reg <= cfg.data;
            else
                height_reg <= cfg.data;
        end
    end

    tssg_control u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_op(in_ch.operation), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .cmd(cmd), .idle(idle)
    );

    tssg_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .ax(in_ch.ax), .ay(in_ch.ay), .bx(in_ch.bx), .by(in_ch.by),
        .cx(in_ch.cx), .cy(in_ch.cy), .fill(in_ch.fill),
        .screen_width(width_reg), .screen_height(idle ? height_reg : height_reg),
        .span_y(out_ch.span_y), .span_left(out_ch.span_left),
        .span_right(out_ch.span_right), .span_color(out_ch.span_color),
        .span_visible(out_ch.span_visible), .span_last(out_ch.span_last)
    );
endmodule
